// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files
// no dependencies; expects a clock named clk and a reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lphm_pkg.sv =====
// shared types and constants of the linear probing hash map
// no dependencies
package lphm_pkg;

	localparam int KEY_W     = 32;
	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 11;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_FIND    = 1'b1;
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] value_out;
		logic               status;
		logic [COUNT_W-1:0] entry_count;
	} result_t;

endpackage

// ===== rtl/lphm_slot_ram.sv =====
// slot memory: one write port, one read port, registered read data
// depends on nothing
module lphm_slot_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 65
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/lphm_mod_unit.sv =====
// key modulo capacity by reciprocal multiplication over pipeline stages s1, s2 and the remainder register
// depends on lphm_pkg
module lphm_mod_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lphm_pkg::KEY_W-1:0]   key,
	output logic                         done,
	output logic [$clog2(CAPACITY)-1:0]  home
);

	localparam int KW = lphm_pkg::KEY_W;
	localparam int IW = $clog2(CAPACITY);
	localparam int QS = KW + IW;
	// ceil(2^QS / CAPACITY) gives the exact quotient for every key of KW bits
	localparam longint unsigned RECIP_L =
		((64'd1 << QS) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
	localparam logic [KW:0]   RECIP   = (KW + 1)'(RECIP_L);
	localparam logic [IW-1:0] CAP_LOW = IW'(CAPACITY);

	logic                 vld_s1;
	logic                 vld_s2;
	logic                 done_q;
	logic [KW-1:0]        key_s1;
	logic [IW-1:0]        key_s2;
	logic [2*KW:0]        prod_s2;
	logic [IW-1:0]        rem_q;
	logic [IW-1:0]        quot_low;
	logic [IW-1:0]        rem_next;

	// only the low bits of quotient times capacity matter for the remainder
	assign quot_low = prod_s2[QS +: IW];
	assign rem_next = key_s2 - quot_low * CAP_LOW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
		end
		if (vld_s1) begin
			key_s2  <= key_s1[IW-1:0];
			prod_s2 <= (2*KW+1)'(key_s1) * (2*KW+1)'(RECIP);
		end
		if (vld_s2) begin
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule

// ===== rtl/linear_probe_hash_map_unit.sv =====
// linear probing hash map: control, probe pipeline and result register
// depends on lphm_pkg, lphm_mod_unit, lphm_slot_ram and assert_macros.svh
//
//  channel  handshake            payload
//  in       in_valid / in_stall  command, key, value_in
//  out      out_valid/ out_stall found, value_out, status, entry_count
//
// after reset a clearing pass over every slot empties the slot memory; in_stall is high
// after acceptance the modulo unit finds the home slot, the probe address loads it,
// L slots (1 to CAPACITY) are read and checked, and the finish step loads the result
// the walk is bound by the single read port; a new item is taken only back in idle
// a new item is taken while a result waits in the output register; a stalled
// result holds the block in its finish step
`include "assert_macros.svh"

module linear_probe_hash_map_unit #(
	parameter int CAPACITY   = 1024,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [lphm_pkg::KEY_W-1:0]       key,
	input  logic [lphm_pkg::VALUE_W-1:0]     value_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic [lphm_pkg::VALUE_W-1:0]     value_out,
	output logic                             status,
	output logic [lphm_pkg::COUNT_W-1:0]     entry_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (KEY_BITS < lphm_pkg::KEY_W) ? KEY_BITS : lphm_pkg::KEY_W;
	localparam int VW = (VALUE_BITS < lphm_pkg::VALUE_W) ? VALUE_BITS : lphm_pkg::VALUE_W;
	localparam int EW = 1 + KW + VW;
	localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
	localparam logic [CW-1:0] LAST_C    = CW'(CAPACITY - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]            state_q;
	logic [IW-1:0]         clr_idx_q;
	logic                  cmd_q;
	logic [KW-1:0]         key_q;
	logic [VW-1:0]         val_q;
	logic [IW-1:0]         addr_q;
	logic [CW-1:0]         issued_q;
	logic [CW-1:0]         checked_q;
	logic                  rvalid_s1;
	logic [IW-1:0]         addr_s1;
	logic [IW-1:0]         where_q;
	logic                  hit_q;
	logic                  full_q;
	logic [VW-1:0]         hit_val_q;
	logic [CW-1:0]         count_q;
	logic                  out_valid_q;
	lphm_pkg::result_t     res_q;

	logic                  in_accept;
	logic                  mod_done;
	logic [IW-1:0]         home;
	logic                  issue;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [EW-1:0]         wr_data;
	logic [EW-1:0]         rd_data;
	logic                  ent_used;
	logic [KW-1:0]         ent_key;
	logic [VW-1:0]         ent_val;
	logic                  ent_empty;
	logic                  ent_match;
	logic                  stop_now;
	logic                  fin_load;
	logic                  is_insert;
	logic                  add_entry;
	logic [CW-1:0]         count_next;
	lphm_pkg::result_t     res_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	lphm_mod_unit #(
		.CAPACITY (CAPACITY)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.key    (lphm_pkg::KEY_W'(key[KW-1:0])),
		.done   (mod_done),
		.home   (home)
	);

	lphm_slot_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (EW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// probe reads run one slot per cycle; the check trails the read through the registered read data
	assign issue     = (state_q == ST_PROBE) && (issued_q != CAP_C);
	assign ent_used  = rd_data[KW+VW];
	assign ent_key   = rd_data[VW +: KW];
	assign ent_val   = rd_data[VW-1:0];
	assign ent_empty = !ent_used;
	assign ent_match = ent_used && (ent_key == key_q);
	assign stop_now  = rvalid_s1 && (ent_empty || ent_match || (checked_q == LAST_C));

	assign fin_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign is_insert  = (cmd_q == lphm_pkg::CMD_INSERT);
	assign add_entry  = is_insert && !full_q && !hit_q;
	assign count_next = count_q + CW'(add_entry);

	always_comb begin
		res_next.found       = hit_q;
		res_next.value_out   = (!is_insert && hit_q) ? lphm_pkg::VALUE_W'(hit_val_q) : '0;
		res_next.status      = (is_insert && full_q) ? lphm_pkg::STATUS_FULL
		                                             : lphm_pkg::STATUS_DONE;
		res_next.entry_count = lphm_pkg::COUNT_W'(count_next);
	end

	// single write port: clearing pass or the finishing insert
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else begin
			wr_en   = fin_load && is_insert && !full_q;
			wr_addr = where_q;
			wr_data = {1'b1, key_q, val_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			issued_q    <= '0;
			checked_q   <= '0;
			rvalid_s1   <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= issue && !stop_now;
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IW'(1);
					if (clr_idx_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					issued_q  <= '0;
					checked_q <= '0;
					if (mod_done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (stop_now) begin
						state_q <= ST_FIN;
					end else begin
						if (issue) begin
							issued_q <= issued_q + CW'(1);
						end
						if (rvalid_s1) begin
							checked_q <= checked_q + CW'(1);
						end
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= command;
			key_q <= key[KW-1:0];
			val_q <= value_in[VW-1:0];
		end
		if (mod_done) begin
			addr_q <= home;
		end else if (issue) begin
			addr_q <= (addr_q == LAST_SLOT) ? '0 : addr_q + IW'(1);
		end
		addr_s1 <= addr_q;
		if (stop_now) begin
			where_q   <= addr_s1;
			hit_q     <= ent_match;
			full_q    <= !ent_empty && !ent_match;
			hit_val_q <= ent_val;
		end
		if (fin_load) begin
			res_q <= res_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = res_q.found;
	assign value_out   = res_q.value_out;
	assign status      = res_q.status;
	assign entry_count = res_q.entry_count;

	`ASSERT_IMPL(a_no_write_in_probe, state_q == ST_PROBE, !wr_en, "slot write during probe walk")
	`ASSERT_ALWAYS(a_count_bound, count_q <= CAP_C, "entry count above capacity")
	`ASSERT_IMPL(a_check_bound, rvalid_s1, checked_q < CAP_C, "probe checked more than one pass")
	`ASSERT_NEXT(a_result_shown, fin_load, out_valid && (state_q == ST_IDLE), "finished item not presented")
	`ASSERT_IMPL(a_hash_done_state, mod_done, state_q == ST_HASH, "home slot ready outside hash step")

endmodule
